// ----- design/ppk_pkg.sv -----
package ppk_pkg;

	localparam int TABLE_DEPTH = 8;

	localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
	localparam int WEIGHT_W   = 8;
	localparam int CHAN_W     = 8;
	localparam int ENTRY_W    = 3 * CHAN_W + WEIGHT_W;
	localparam int DRAW_W     = 11;
	localparam int SUM_W      = $clog2(TABLE_DEPTH * 255 + 1);
	localparam int CMP_W      = (SUM_W > DRAW_W) ? SUM_W : DRAW_W;
	localparam int LPS_W      = 11;
	localparam int PIXEL_W    = 8;
	localparam int STRAND_W   = 4;
	localparam int ADDR_W     = 14;
	localparam int INDEX_W    = 3;
	localparam int CMD_W      = 2;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 48;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PICK  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LPS     = 1'b1;

	localparam logic [LPS_W-1:0] LPS_RESET = 11'd64;

	typedef struct packed {
		logic              start;
		logic              uniform;
		logic [DRAW_W-1:0] draw;
		logic [CNT_W-1:0]  count;
	} walk_ctl_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [IDX_W-1:0] pick;
	} walk_sts_t;

endpackage

// ----- design/ppk_ram.sv -----
module ppk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/ppk_walk.sv -----
module ppk_walk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ppk_pkg::walk_ctl_t              ctl,
	output ppk_pkg::walk_sts_t              sts,
	output logic [ppk_pkg::IDX_W-1:0]       rd_addr,
	input  logic [ppk_pkg::WEIGHT_W-1:0]    rd_weight
);
	import ppk_pkg::*;

	logic                issue_q;
	logic                dval_q;
	logic                found_q;
	logic                done_q;
	logic [IDX_W-1:0]    addr_q;
	logic [IDX_W-1:0]    didx_q;
	logic [IDX_W-1:0]    best_q;
	logic [WEIGHT_W-1:0] bw_q;
	logic [SUM_W-1:0]    sum_q;

	logic [IDX_W-1:0] last_idx;
	logic [SUM_W-1:0] sum_n;
	logic             hit;
	logic             better;

	assign last_idx = IDX_W'(ctl.count - CNT_W'(1));
	// shared accumulate / compare unit, one entry per cycle
	assign sum_n  = sum_q + SUM_W'(rd_weight);
	assign hit    = !found_q && (CMP_W'(sum_n) > CMP_W'(ctl.draw));
	assign better = (didx_q == '0) || (rd_weight > bw_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			dval_q  <= 1'b0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				issue_q <= 1'b1;
				dval_q  <= 1'b0;
				found_q <= 1'b0;
			end else begin
				dval_q <= issue_q;
				if (issue_q && addr_q == last_idx) begin
					issue_q <= 1'b0;
				end
				if (dval_q) begin
					if (!ctl.uniform && hit) begin
						found_q <= 1'b1;
					end
					if (didx_q == last_idx) begin
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			addr_q <= '0;
			sum_q  <= '0;
		end else begin
			didx_q <= addr_q;
			if (issue_q && addr_q != last_idx) begin
				addr_q <= addr_q + IDX_W'(1);
			end
			if (dval_q) begin
				sum_q <= sum_n;
				if (ctl.uniform) begin
					if (better) begin
						best_q <= didx_q;
						bw_q   <= rd_weight;
					end
				end else if (hit) begin
					best_q <= didx_q;
				end
				// draw at or above total: last entry
				if (didx_q == last_idx && !ctl.uniform && !found_q && !hit) begin
					best_q <= last_idx;
				end
			end
		end
	end

	assign rd_addr   = addr_q;
	assign sts.busy  = issue_q | dval_q;
	assign sts.done  = done_q;
	assign sts.pick  = best_q;

endmodule

// ----- design/weighted_palette_picker_top.sv -----
// Clear and add: one transaction per cycle, taken in the accept cycle, no result.
// Pick on a table of N entries: the result passes through WALK, FETCH and RES to the result register;
// the walk reads one entry per cycle through the single RAM read port.
// Pick on an empty table: goes straight to RES, no_entry set.
// One pick in flight: s_tready drops until the result is registered.
// Reset (arst_n low, asynchronous): table empty, uniform_mode 0, leds_per_strand 64.
module weighted_palette_picker_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// red[7:0] green[15:8] blue[23:16] weight[31:24] draw[42:32]
	// pixel[50:43] strand[54:51], zero pad [55]
	input  logic [ppk_pkg::IN_DATA_W-1:0]       s_tdata,
	// command[1:0]
	input  logic [ppk_pkg::CMD_W-1:0]           s_tuser,
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// entry_index[2:0] red[10:3] green[18:11] blue[26:19]
	// led_address[40:27], zero pad [47:41]
	output logic [ppk_pkg::OUT_DATA_W-1:0]      m_tdata,
	// no_entry[0]
	output logic                                m_tuser,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ppk_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ppk_pkg::LPS_W-1:0]           cfg_data
);
	import ppk_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FETCH = 2'd2;
	localparam logic [1:0] ST_RES   = 2'd3;

	localparam int PROD_W  = LPS_W + STRAND_W;
	localparam int OUT_PAD = OUT_DATA_W - (INDEX_W + 3 * CHAN_W + ADDR_W);

	// configuration registers
	logic             uniform_q;
	logic [LPS_W-1:0] lps_q;

	// control
	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic             noent_q;

	// per-pick payload
	logic [DRAW_W-1:0] draw_q;
	logic [ADDR_W-1:0] led_q;

	// result register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_noent_q;

	// input fields
	logic [CMD_W-1:0]    cmd;
	logic [CHAN_W-1:0]   red_in;
	logic [CHAN_W-1:0]   green_in;
	logic [CHAN_W-1:0]   blue_in;
	logic [WEIGHT_W-1:0] weight_in;
	logic [DRAW_W-1:0]   draw_in;
	logic [PIXEL_W-1:0]  pixel_in;
	logic [STRAND_W-1:0] strand_in;

	assign cmd       = s_tuser;
	assign red_in    = s_tdata[7:0];
	assign green_in  = s_tdata[15:8];
	assign blue_in   = s_tdata[23:16];
	assign weight_in = s_tdata[31:24];
	assign draw_in   = s_tdata[42:32];
	assign pixel_in  = s_tdata[50:43];
	assign strand_in = s_tdata[54:51];

	logic              in_acc;
	logic              full;
	logic              load;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [IDX_W-1:0]  walk_addr;
	logic [PROD_W-1:0] led_full;
	walk_ctl_t         walk_ctl;
	walk_sts_t         walk_sts;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(TABLE_DEPTH));

	// Add to a full table restarts it at entry 0.
	assign ram_we    = in_acc && (cmd == CMD_ADD);
	assign ram_waddr = full ? '0 : IDX_W'(count_q);
	assign ram_wdata = {red_in, green_in, blue_in, weight_in};

	// The walker owns the read port while walking; afterwards the port
	// is held on the chosen entry so its colour stays on rdata.
	assign ram_raddr = (state_q == ST_WALK) ? walk_addr : walk_sts.pick;

	// strand * leds_per_strand + pixel, wrapped to the address width
	assign led_full = PROD_W'(strand_in) * PROD_W'(lps_q) + PROD_W'(pixel_in);

	assign walk_ctl.start   = in_acc && (cmd == CMD_PICK) && (count_q != '0);
	assign walk_ctl.uniform = uniform_q;
	assign walk_ctl.draw    = draw_q;
	assign walk_ctl.count   = count_q;

	assign load = (state_q == ST_RES) && (!out_valid_q || m_tready);

	ppk_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ppk_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (walk_ctl),
		.sts       (walk_sts),
		.rd_addr   (walk_addr),
		.rd_weight (ram_rdata[WEIGHT_W-1:0])
	);

	// Config writes only land while idle, so a walk never sees a mode change.
	assign cfg_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uniform_q <= 1'b0;
			lps_q     <= LPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_UNIFORM: begin
					uniform_q <= cfg_data[0];
				end
				CFG_LPS: begin
					lps_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer: IDLE -> WALK -> FETCH -> RES -> IDLE, empty pick goes straight to RES
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			noent_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (cmd)
							CMD_CLEAR: begin
								count_q <= '0;
							end
							CMD_ADD: begin
								count_q <= full ? CNT_W'(1) : count_q + CNT_W'(1);
							end
							CMD_PICK: begin
								noent_q <= (count_q == '0);
								state_q <= (count_q == '0) ? ST_RES : ST_WALK;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					if (walk_sts.done) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && cmd == CMD_PICK) begin
			draw_q <= draw_in;
			led_q  <= led_full[ADDR_W-1:0];
		end
	end

	// output register parts the result from the next input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_noent_q <= noent_q;
			if (noent_q) begin
				out_data_q <= '0;
			end else begin
				out_data_q <= {{OUT_PAD{1'b0}}, led_q,
					ram_rdata[ENTRY_W-3*CHAN_W +: CHAN_W],
					ram_rdata[ENTRY_W-2*CHAN_W +: CHAN_W],
					ram_rdata[ENTRY_W-CHAN_W +: CHAN_W],
					INDEX_W'(walk_sts.pick)};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_noent_q;

`ifndef ASSERT_OFF
	a_ready_not_walking: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !walk_sts.busy)
		else $error("input ready while walker busy");

	a_done_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		walk_sts.done |-> (state_q == ST_WALK))
		else $error("walker done outside walk state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_pick_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !noent_q) |-> (CNT_W'(walk_sts.pick) < count_q))
		else $error("picked entry beyond entry count");
`endif

endmodule

// ----- tb/weighted_palette_picker_top_tb.sv -----
`timescale 1ns / 1ps

module weighted_palette_picker_top_tb;

	import ppk_pkg::*;

	// command code that the block must swallow without a result
	localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

	localparam int RANDOM_ITEMS = 1950;
	localparam int PHASES       = 6;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 12;

	// one input transaction, fields in natural form
	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [CHAN_W-1:0]   red;
		logic [CHAN_W-1:0]   green;
		logic [CHAN_W-1:0]   blue;
		logic [WEIGHT_W-1:0] weight;
		logic [DRAW_W-1:0]   draw;
		logic [PIXEL_W-1:0]  pixel;
		logic [STRAND_W-1:0] strand;
	} palette_cmd_t;

	// one expected result transaction
	typedef struct packed {
		logic                none;
		logic [ADDR_W-1:0]   address;
		logic [CHAN_W-1:0]   red;
		logic [CHAN_W-1:0]   green;
		logic [CHAN_W-1:0]   blue;
		logic [INDEX_W-1:0]  slot_idx;
	} pick_t;

	// Shadow of the palette table plus the queue of picks still owed by the block.
	class palette_tracker;
		bit                  uniform_sel;
		bit [LPS_W-1:0]      pixels_per_strand;
		int unsigned         fill;
		bit [3*CHAN_W-1:0]   colour [TABLE_DEPTH];
		bit [WEIGHT_W-1:0]   weight [TABLE_DEPTH];
		pick_t               owed_picks [$];
		int                  errors;
		int                  commands_seen;
		int                  picks_checked;
		int                  empty_picks;
		int                  reg_writes;

		function new();
			uniform_sel       = 1'b0;
			pixels_per_strand = LPS_RESET;
			fill              = 0;
			errors            = 0;
			commands_seen     = 0;
			picks_checked     = 0;
			empty_picks       = 0;
			reg_writes        = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LPS_W-1:0] data);
			reg_writes++;
			if (idx == CFG_UNIFORM) begin
				uniform_sel = data[0];
			end else if (idx == CFG_LPS) begin
				pixels_per_strand = data;
			end
		endfunction

		function int unsigned total_weight();
			int unsigned sum;
			sum = 0;
			for (int i = 0; i < fill; i++) begin
				sum += weight[i];
			end
			return sum;
		endfunction

		function int pending();
			return owed_picks.size();
		endfunction

		// apply one accepted command; a pick queues the result it must produce
		function void note_command(palette_cmd_t c);
			int unsigned slot;
			int unsigned best;
			int unsigned sum;
			bit [WEIGHT_W-1:0] best_w;
			bit [31:0] addr;
			pick_t p;
			commands_seen++;
			case (c.cmd)
				CMD_CLEAR: begin
					fill = 0;
				end
				CMD_ADD: begin
					// a full table starts over at slot 0
					if (fill >= TABLE_DEPTH) begin
						slot = 0;
						fill = 1;
					end else begin
						slot = fill;
						fill++;
					end
					colour[slot] = {c.red, c.green, c.blue};
					weight[slot] = c.weight;
				end
				CMD_PICK: begin
					p = '0;
					if (fill == 0) begin
						p.none = 1'b1;
					end else begin
						best = fill - 1;  // draw past the total lands on the last entry
						if (uniform_sel) begin
							best   = 0;
							best_w = weight[0];
							for (int i = 1; i < fill; i++) begin
								if (weight[i] > best_w) begin
									best_w = weight[i];
									best   = i;
								end
							end
						end else begin
							sum = 0;
							for (int i = 0; i < fill; i++) begin
								sum += weight[i];
								if (sum > c.draw) begin
									best = i;
									break;
								end
							end
						end
						p.slot_idx = best[INDEX_W-1:0];
						{p.red, p.green, p.blue} = colour[best];
						addr = 32'(c.strand) * 32'(pixels_per_strand) + 32'(c.pixel);
						p.address = addr[ADDR_W-1:0];
					end
					owed_picks.push_back(p);
				end
				default: begin
				end
			endcase
		endfunction

		function void cmp(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %0d actual %0d",
					$time, field, want, got);
			end
		endfunction

		function void check_pick(logic [OUT_DATA_W-1:0] d, logic none);
			pick_t want;
			if (owed_picks.size() == 0) begin
				errors++;
				$display("%0t ns: result with nothing outstanding, expected none actual data %h flag %0b",
					$time, d, none);
				return;
			end
			want = owed_picks.pop_front();
			picks_checked++;
			if (want.none) empty_picks++;
			cmp("entry_index", want.slot_idx, d[2:0]);
			cmp("red_out",     want.red,      d[10:3]);
			cmp("green_out",   want.green,    d[18:11]);
			cmp("blue_out",    want.blue,     d[26:19]);
			cmp("led_address", want.address,  d[40:27]);
			cmp("no_entry",    want.none,     none);
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata;
	logic [CMD_W-1:0]        s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic                    m_tuser;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [LPS_W-1:0]        cfg_data;

	palette_tracker tracker;

	// shared between the stimulus thread and the receiver
	bit calm     = 1'b0;  // no idling on either side
	bit hold_req = 1'b0;  // ask the receiver for one long hold-off

	weighted_palette_picker_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Monitor: everything is sampled at the rising edge; inputs only move on the
	// falling edge, so the values seen here are stable.
	always @(posedge clk) begin
		palette_cmd_t seen;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				seen.cmd    = s_tuser;
				seen.red    = s_tdata[7:0];
				seen.green  = s_tdata[15:8];
				seen.blue   = s_tdata[23:16];
				seen.weight = s_tdata[31:24];
				seen.draw   = s_tdata[42:32];
				seen.pixel  = s_tdata[50:43];
				seen.strand = s_tdata[54:51];
				tracker.note_command(seen);
			end
			if (m_tvalid && m_tready) begin
				tracker.check_pick(m_tdata, m_tuser);
			end
			if (cfg_valid && cfg_ready) begin
				tracker.write_reg(cfg_index, cfg_data);
			end
		end
	end

	// Receiver: about a third of the cycles stalled, none while calm, and one
	// long hold-off on request so a pick result backs up and s_tready drops.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_left = 300;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (calm) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 34);
			end
		end
	end

	// Hard stop in case the block hangs
	initial begin
		#1000000;
		$display("FAIL weighted_palette_picker_top");
		$finish;
	end

	// Called on a falling edge; returns on the falling edge after acceptance with
	// s_tvalid still high, so a back-to-back transaction keeps it up.
	task automatic send_cmd(input palette_cmd_t c);
		s_tvalid <= 1'b1;
		s_tuser  <= c.cmd;
		s_tdata  <= {1'b0, c.strand, c.pixel, c.draw, c.weight, c.blue, c.green, c.red};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// random sender idle, with junk on the data lines while tvalid is low
	task automatic sender_pause();
		if (!calm && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			s_tdata  <= IN_DATA_W'({$urandom, $urandom});
			s_tuser  <= CMD_W'($urandom);
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
	endtask

	task automatic offer(input logic [CMD_W-1:0] cmd, input int r, input int g, input int b,
			input int w, input int draw, input int pixel, input int strand);
		palette_cmd_t c;
		c.cmd    = cmd;
		c.red    = CHAN_W'(r);
		c.green  = CHAN_W'(g);
		c.blue   = CHAN_W'(b);
		c.weight = WEIGHT_W'(w);
		c.draw   = DRAW_W'(draw);
		c.pixel  = PIXEL_W'(pixel);
		c.strand = STRAND_W'(strand);
		sender_pause();
		send_cmd(c);
	endtask

	// Drain: every pick answered, then enough cycles for a trailing add/clear
	// or anything the walk still has in flight.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (tracker.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// both registers back to back; cfg_valid stays up between the two
	task automatic set_mode(input bit uniform, input int lps);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_UNIFORM;
		cfg_data  <= LPS_W'(uniform);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_index <= CFG_LPS;
		cfg_data  <= LPS_W'(lps);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Random traffic: mostly adds and picks so the table fills, wraps and gets
	// walked; draws mostly land near the running total to hit each entry.
	task automatic random_phase(input int n);
		palette_cmd_t c;
		int done_items;
		int roll;
		int unsigned lim;
		done_items = 0;
		while (done_items < n) begin
			roll     = $urandom_range(99);
			c.red    = CHAN_W'($urandom);
			c.green  = CHAN_W'($urandom);
			c.blue   = CHAN_W'($urandom);
			c.pixel  = PIXEL_W'($urandom);
			c.strand = STRAND_W'($urandom);
			// a few fixed weights so ties and zero weights show up
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(2))
					0: c.weight = 8'd0;
					1: c.weight = 8'd128;
					default: c.weight = 8'd255;
				endcase
			end else begin
				c.weight = WEIGHT_W'($urandom);
			end
			lim = tracker.total_weight() + 8;
			if (lim > 2047) lim = 2047;
			if ($urandom_range(9) < 7) begin
				c.draw = DRAW_W'($urandom_range(lim));
			end else begin
				c.draw = DRAW_W'($urandom);
			end
			if (roll < 4) begin
				c.cmd = CMD_CLEAR;
			end else if (roll < 7) begin
				c.cmd = CMD_IGNORED;
			end else if (roll < 40) begin
				c.cmd = CMD_ADD;
			end else begin
				c.cmd = CMD_PICK;
			end
			sender_pause();
			send_cmd(c);
			done_items++;
		end
	endtask

	initial begin
		tracker   = new();
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = CMD_CLEAR;
		cfg_valid = 1'b0;
		cfg_index = CFG_UNIFORM;
		cfg_data  = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed, reset settings: weighted draw, 64 pixels per strand ---
		offer(CMD_PICK, 0, 0, 0, 0, 2047, 255, 15);     // empty table
		offer(CMD_ADD, 255, 0, 0, 0, 0, 0, 0);
		offer(CMD_ADD, 0, 255, 0, 255, 0, 0, 0);
		offer(CMD_ADD, 0, 0, 255, 1, 0, 0, 0);
		offer(CMD_PICK, 0, 0, 0, 0, 0, 0, 0);           // skips the zero-weight head
		offer(CMD_PICK, 0, 0, 0, 0, 255, 255, 15);      // lands on the last boundary
		offer(CMD_PICK, 0, 0, 0, 0, 2047, 1, 1);        // draw past total
		offer(CMD_IGNORED, 255, 255, 255, 255, 2047, 255, 15);
		for (int i = 0; i < 5; i++) begin
			offer(CMD_ADD, i * 40, 255 - i, i, 255, 0, 0, 0);
		end
		offer(CMD_PICK, 0, 0, 0, 0, 300, 17, 3);        // full table walk
		offer(CMD_ADD, 17, 34, 51, 9, 0, 0, 0);         // add to full: restart
		offer(CMD_PICK, 0, 0, 0, 0, 0, 2, 2);
		offer(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		offer(CMD_ADD, 1, 2, 3, 0, 0, 0, 0);
		offer(CMD_ADD, 4, 5, 6, 0, 0, 0, 0);
		offer(CMD_PICK, 0, 0, 0, 0, 0, 9, 1);           // all weights zero
		settle();

		// --- directed, heaviest-entry mode, widest strand (address wraps) ---
		set_mode(1'b1, 2047);
		offer(CMD_PICK, 0, 0, 0, 0, 0, 255, 15);        // all zero: entry 0
		offer(CMD_ADD, 7, 8, 9, 200, 0, 0, 0);
		offer(CMD_ADD, 10, 11, 12, 200, 0, 0, 0);
		offer(CMD_PICK, 0, 0, 0, 0, 2047, 255, 15);     // tie: first heaviest
		settle();

		// --- directed, zero pixels per strand: address is the pixel ---
		set_mode(1'b0, 0);
		offer(CMD_PICK, 0, 0, 0, 0, 5, 7, 15);
		settle();

		// --- random phases, each under its own register setting ---
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_mode(1'b0, 1);
				1: set_mode(1'b1, 1024);
				2: set_mode(1'b0, 2047);
				3: set_mode(1'b1, 0);
				4: set_mode(1'b0, $urandom_range(1024, 1));
				default: set_mode(1'b1, $urandom_range(1024, 1));
			endcase
			hold_req = (ph == 1);
			calm     = (ph == 2);
			random_phase(RANDOM_ITEMS / PHASES);
			settle();
			calm = 1'b0;
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d commands over %0d register writes, both pick modes and address extremes.",
			tracker.commands_seen, tracker.reg_writes);
		$display("Checked %0d picks, %0d of them on an empty table; %0d errors.",
			tracker.picks_checked, tracker.empty_picks, tracker.errors);
		if (tracker.errors == 0) begin
			$display("PASS weighted_palette_picker_top");
		end else begin
			$display("FAIL weighted_palette_picker_top");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/ppk_pkg.sv
design/ppk_ram.sv
design/ppk_walk.sv
design/weighted_palette_picker_top.sv
tb/weighted_palette_picker_top_tb.sv
